FILE: design/fius_pkg.sv
// fius_pkg: shared types, codes and constants of the flash image update sequencer
// used by fius_ctrl, fius_dp and flash_image_update_sequencer_top
package fius_pkg;

  localparam int unsigned SLOT_BYTES_DEF   = 1048576;
  localparam int unsigned SECTOR_BYTES_DEF = 4096;
  localparam int unsigned SIG_BYTES_DEF    = 8;

  localparam int unsigned OFF_W  = 21;  // byte offset inside a slot
  localparam int unsigned ADDR_W = 22;  // flash offset
  localparam int unsigned IDX_W  = 5;   // commit step counter, SIG_BYTES + 4 steps

  localparam logic [ADDR_W-1:0] SLOT0_BASE = 22'h006000;
  localparam logic [ADDR_W-1:0] SLOT1_BASE = 22'h106000;
  localparam logic [31:0]       CRC_POLY   = 32'hEDB88320;
  localparam logic [31:0]       CRC_INIT   = 32'hFFFFFFFF;
  localparam logic [7:0]        SIG_FILL   = 8'hFF;

  // request kinds
  localparam logic [1:0] KIND_BEGIN = 2'd0;
  localparam logic [1:0] KIND_DATA  = 2'd1;
  localparam logic [1:0] KIND_END   = 2'd2;
  localparam logic [1:0] KIND_ABORT = 2'd3;

  // flash operations
  localparam logic [1:0] OP_STATUS  = 2'd0;
  localparam logic [1:0] OP_ERASE   = 2'd1;
  localparam logic [1:0] OP_PROGRAM = 2'd2;

  // result source selects
  localparam logic [2:0] EM_STATUS = 3'd0;
  localparam logic [2:0] EM_ERASE  = 3'd1;
  localparam logic [2:0] EM_DATA   = 3'd2;
  localparam logic [2:0] EM_SIG    = 3'd3;
  localparam logic [2:0] EM_ZERO   = 3'd4;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] image_size;
    logic [7:0]  data_byte;
    logic [20:0] chunk_left;
    logic [31:0] expected_crc;
  } fius_in_t;

  typedef struct packed {
    logic [1:0]  flash_op;
    logic [21:0] flash_addr;
    logic [7:0]  program_byte;
    logic        ok;
    logic        last;
  } fius_out_t;

  typedef struct packed {
    logic             load;      // capture the accepted request
    logic             emit;      // load one result into the output register
    logic [2:0]       emit_sel;
    logic             ok;
    logic             last;
    logic [IDX_W-1:0] idx;       // commit step
    logic             do_begin;
    logic             do_erase;
    logic             do_data;
    logic             do_stop;   // clear busy
    logic             clr_bw;    // clear bytes written
  } fius_cmd_t;

  typedef struct packed {
    logic [1:0] kind;
    logic       begin_ok;
    logic       data_ok;
    logic       need_erase;
    logic       need_prog;
    logic       busy;
    logic       crc_match;
    logic       out_free;
  } fius_sts_t;

  function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int i = 0; i < 8; i++) begin
      c = (c >> 1) ^ (c[0] ? CRC_POLY : 32'd0);
    end
    return c;
  endfunction

endpackage

FILE: design/fius_ctrl.sv
// fius_ctrl: request sequencer, decides which results a request gives
// depends on fius_pkg; drives fius_dp through fius_cmd_t
module fius_ctrl
  import fius_pkg::*;
#(
  parameter int unsigned SIG_BYTES = SIG_BYTES_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  fius_sts_t sts,
  output fius_cmd_t cmd
);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_DECIDE = 2'd1;
  localparam logic [1:0] S_PROG   = 2'd2;
  localparam logic [1:0] S_COMMIT = 2'd3;

  localparam logic [IDX_W-1:0] IDX_SIG  = IDX_W'(SIG_BYTES);
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(SIG_BYTES + 3);

  logic [1:0]       state_r, state_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;

  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    cmd       = '0;
    cmd.idx   = idx_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          idx_nxt   = '0;
          state_nxt = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (sts.out_free) begin
          cmd.emit     = 1'b1;
          cmd.emit_sel = EM_STATUS;
          cmd.last     = 1'b1;
          state_nxt    = S_IDLE;
          case (sts.kind)
            KIND_BEGIN: begin
              cmd.ok       = sts.begin_ok;
              cmd.do_begin = sts.begin_ok;
            end
            KIND_DATA: begin
              if (sts.data_ok) begin
                cmd.ok = 1'b1;
                if (sts.need_erase) begin
                  cmd.emit_sel = EM_ERASE;
                  cmd.do_erase = 1'b1;
                  if (sts.need_prog) begin
                    cmd.last  = 1'b0;
                    state_nxt = S_PROG;
                  end else begin
                    cmd.do_data = 1'b1;
                  end
                end else begin
                  if (sts.need_prog) cmd.emit_sel = EM_DATA;
                  cmd.do_data = 1'b1;
                end
              end
            end
            KIND_END: begin
              if (sts.busy && sts.crc_match) begin
                cmd.ok       = 1'b1;
                cmd.emit_sel = EM_SIG;
                cmd.last     = 1'b0;
                idx_nxt      = idx_r + 1'b1;
                state_nxt    = S_COMMIT;
              end else if (sts.busy) begin
                // crc mismatch acts as abort
                cmd.do_stop = 1'b1;
                cmd.clr_bw  = 1'b1;
              end
            end
            default: begin
              cmd.ok      = 1'b1;
              cmd.do_stop = 1'b1;
              cmd.clr_bw  = 1'b1;
            end
          endcase
        end
      end
      S_PROG: begin
        if (sts.out_free) begin
          cmd.emit     = 1'b1;
          cmd.emit_sel = EM_DATA;
          cmd.ok       = 1'b1;
          cmd.last     = 1'b1;
          cmd.do_data  = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      S_COMMIT: begin
        if (sts.out_free) begin
          cmd.emit     = 1'b1;
          cmd.emit_sel = (idx_r < IDX_SIG) ? EM_SIG : EM_ZERO;
          cmd.ok       = 1'b1;
          if (idx_r == IDX_LAST) begin
            cmd.last    = 1'b1;
            cmd.do_stop = 1'b1;
            state_nxt   = S_IDLE;
          end else begin
            idx_nxt = idx_r + 1'b1;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      idx_r   <= '0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
    end
  end

endmodule

FILE: design/fius_dp.sv
// fius_dp: request register, update state, crc, held signature and result register
// depends on fius_pkg; controlled by fius_ctrl through fius_cmd_t
module fius_dp
  import fius_pkg::*;
#(
  parameter int unsigned SLOT_BYTES   = SLOT_BYTES_DEF,
  parameter int unsigned SECTOR_BYTES = SECTOR_BYTES_DEF,
  parameter int unsigned SIG_BYTES    = SIG_BYTES_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  fius_in_t  in_item,
  input  logic      cfg_we,
  input  logic      cfg_wdata,
  input  fius_cmd_t cmd,
  output fius_sts_t sts,
  output logic      out_valid,
  input  logic      out_stall,
  output fius_out_t out_item
);

  localparam int unsigned SIG_IW = (SIG_BYTES > 1) ? $clog2(SIG_BYTES) : 1;

  fius_in_t         item_r;
  logic             slot_r;
  logic             busy_r;
  logic [OFF_W-1:0] bw_r;
  logic [OFF_W-1:0] el_r;
  logic [31:0]      crc_r;
  logic [7:0]       sig_r [SIG_BYTES];
  logic             out_valid_r;
  fius_out_t        out_r, out_nxt;

  logic [OFF_W-1:0]  left_eff;
  logic [OFF_W:0]    chunk_end;
  logic [ADDR_W-1:0] target_base, run_base, base, offs;
  logic [IDX_W-1:0]  zero_idx;
  logic [31:0]       crc_nxt;

  assign target_base = slot_r ? SLOT0_BASE : SLOT1_BASE;
  assign run_base    = slot_r ? SLOT1_BASE : SLOT0_BASE;
  assign left_eff    = (item_r.chunk_left == '0) ? OFF_W'(1) : item_r.chunk_left;
  assign chunk_end   = {1'b0, bw_r} + {1'b0, left_eff};
  assign zero_idx    = cmd.idx - IDX_W'(SIG_BYTES);
  assign crc_nxt     = crc_byte(crc_r, item_r.data_byte);

  always_comb begin
    sts.kind       = item_r.kind;
    sts.begin_ok   = !(item_r.image_size < 32'(SIG_BYTES) ||
                       item_r.image_size > 32'(SLOT_BYTES));
    sts.data_ok    = busy_r && (chunk_end <= (OFF_W+1)'(SLOT_BYTES));
    sts.need_erase = (el_r <= bw_r);
    sts.need_prog  = (bw_r >= OFF_W'(SIG_BYTES));
    sts.busy       = busy_r;
    sts.crc_match  = (~crc_r == item_r.expected_crc);
    sts.out_free   = !out_valid_r || !out_stall;
  end

  // result payload: one base and one offset feed a single adder
  always_comb begin
    base                 = target_base;
    offs                 = '0;
    out_nxt              = '0;
    out_nxt.ok           = cmd.ok;
    out_nxt.last         = cmd.last;
    case (cmd.emit_sel)
      EM_ERASE: begin
        out_nxt.flash_op = OP_ERASE;
        offs             = {1'b0, el_r};
      end
      EM_DATA: begin
        out_nxt.flash_op     = OP_PROGRAM;
        offs                 = {1'b0, bw_r};
        out_nxt.program_byte = item_r.data_byte;
      end
      EM_SIG: begin
        out_nxt.flash_op     = OP_PROGRAM;
        offs                 = ADDR_W'(cmd.idx);
        out_nxt.program_byte = sig_r[cmd.idx[SIG_IW-1:0]];
      end
      EM_ZERO: begin
        out_nxt.flash_op = OP_PROGRAM;
        base             = run_base;
        offs             = ADDR_W'(zero_idx[1:0]);
      end
      default: begin
        out_nxt.flash_op = OP_STATUS;
      end
    endcase
    if (cmd.emit_sel != EM_STATUS) out_nxt.flash_addr = base + offs;
  end

  always_ff @(posedge clk) begin
    if (cmd.load) item_r <= in_item;
    if (cmd.emit) out_r <= out_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_r      <= 1'b0;
      busy_r      <= 1'b0;
      bw_r        <= '0;
      el_r        <= '0;
      crc_r       <= CRC_INIT;
      out_valid_r <= 1'b0;
      for (int i = 0; i < SIG_BYTES; i++) sig_r[i] <= SIG_FILL;
    end else begin
      if (cfg_we) slot_r <= cfg_wdata;
      if (cmd.emit) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
      if (cmd.do_begin) begin
        busy_r <= 1'b1;
        bw_r   <= '0;
        el_r   <= '0;
        crc_r  <= CRC_INIT;
        for (int i = 0; i < SIG_BYTES; i++) sig_r[i] <= SIG_FILL;
      end
      if (cmd.do_erase) el_r <= el_r + OFF_W'(SECTOR_BYTES);
      if (cmd.do_data) begin
        if (bw_r < OFF_W'(SIG_BYTES)) sig_r[bw_r[SIG_IW-1:0]] <= item_r.data_byte;
        crc_r <= crc_nxt;
        bw_r  <= bw_r + 1'b1;
      end
      if (cmd.do_stop) busy_r <= 1'b0;
      if (cmd.clr_bw) bw_r <= '0;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

endmodule

FILE: design/flash_image_update_sequencer_top.sv
// flash_image_update_sequencer_top: two-slot flash image update sequencer
// depends on fius_pkg, fius_ctrl and fius_dp
//
// usage:
//   in_valid/in_stall/in_item carry requests: begin, data byte, end, abort.
//   out_valid/out_stall/out_item carry flash commands (erase sector, program
//   byte) or a status result; every request ends with one result marked last,
//   whose ok says whether the request was taken.
//   cfg_we/cfg_wdata write the running slot; write it only while idle.
// sequencing:
//   a request is taken only when the sequencer is idle. its first result is
//   loaded into the output register from the decide state, then one result per
//   cycle while the output is not stalled. status only and most data requests
//   give one result; an end with a crc match gives SIG_BYTES + 4. the single
//   output register sets this pace.
// reset: synchronous on rst_n; the sequencer goes idle, crc and signature are
//   preset, running slot 0.
// stall: a stalled result holds; the sequencer waits and takes no new request
//   until the current request's results have all entered the output register.
module flash_image_update_sequencer_top
  import fius_pkg::*;
#(
  parameter int unsigned SLOT_BYTES   = SLOT_BYTES_DEF,
  parameter int unsigned SECTOR_BYTES = SECTOR_BYTES_DEF,
  parameter int unsigned SIG_BYTES    = SIG_BYTES_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  fius_in_t  in_item,
  output logic      out_valid,
  input  logic      out_stall,
  output fius_out_t out_item,
  input  logic      cfg_we,
  input  logic      cfg_wdata
);

  fius_cmd_t cmd;
  fius_sts_t sts;

  fius_ctrl #(
    .SIG_BYTES(SIG_BYTES)
  ) u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .sts     (sts),
    .cmd     (cmd)
  );

  fius_dp #(
    .SLOT_BYTES  (SLOT_BYTES),
    .SECTOR_BYTES(SECTOR_BYTES),
    .SIG_BYTES   (SIG_BYTES)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_item  (in_item),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .cmd      (cmd),
    .sts      (sts),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_item (out_item)
  );

`ifndef NO_ASSERTIONS
  // one request at a time
  a_one_req: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("request accepted while previous request in progress");

  // a pending result is never overwritten
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> sts.out_free)
    else $error("result register overwritten while stalled");

  // a status result always closes its request
  a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.flash_op == OP_STATUS |-> out_item.last)
    else $error("status result not marked last");

  // new request only after the last result of the previous one was loaded
  a_last_then_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit && !cmd.last |=> in_stall)
    else $error("sequencer idle in the middle of a request");
`endif

endmodule

FILE: tb/testbench.sv
// testbench: self-checking bench for flash_image_update_sequencer_top, a directed table
// followed by random update sequences, each result checked against an in-bench predictor
// or a NAK / ACK row's status; depends on fius_pkg and the design files of the sequencer
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import fius_pkg::*;

  localparam int unsigned SLOT_N      = SLOT_BYTES_DEF;
  localparam int unsigned SECTOR_N    = SECTOR_BYTES_DEF;
  localparam int unsigned SIG_N       = SIG_BYTES_DEF;
  localparam int unsigned IDLE_SETTLE = 4;
  localparam int unsigned DRAIN_TAIL  = 24;
  localparam int unsigned PHASE_ITEMS = 72;

  typedef enum logic [1:0] {CRC_ZERO, CRC_GOOD, CRC_BAD} crc_fill_e;
  typedef enum logic [1:0] {BY_MODEL, NAK, ACK} row_check_e;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] image_size;
    logic [7:0]  data_byte;
    logic [20:0] chunk_left;
    crc_fill_e   crc_fill;
    row_check_e  check;
  } script_row_t;

  // NAK / ACK rows expect a single status result with ok 0 / 1
  localparam script_row_t DIRECTED_SCRIPT [25] = '{
    '{KIND_DATA,  32'd0,          8'h00, 21'd1,       CRC_ZERO, NAK},
    '{KIND_END,   32'd0,          8'h00, 21'd0,       CRC_ZERO, NAK},
    '{KIND_ABORT, 32'd0,          8'h00, 21'd0,       CRC_ZERO, ACK},
    '{KIND_BEGIN, 32'd0,          8'h00, 21'd0,       CRC_ZERO, NAK},
    '{KIND_BEGIN, 32'd7,          8'h00, 21'd0,       CRC_ZERO, NAK},
    '{KIND_BEGIN, 32'd1048577,    8'h00, 21'd0,       CRC_ZERO, NAK},
    '{KIND_BEGIN, 32'hFFFFFFFF,   8'h00, 21'd0,       CRC_ZERO, NAK},
    '{KIND_BEGIN, 32'd1048576,    8'h00, 21'd0,       CRC_ZERO, ACK},
    '{KIND_DATA,  32'd0,          8'h00, 21'd0,       CRC_ZERO, BY_MODEL},
    '{KIND_DATA,  32'd0,          8'hFF, 21'h1FFFFF,  CRC_ZERO, NAK},
    // image shorter than the signature, unwritten signature bytes stay erased
    '{KIND_END,   32'd0,          8'h00, 21'd0,       CRC_GOOD, BY_MODEL},
    '{KIND_BEGIN, 32'd8,          8'h00, 21'd0,       CRC_ZERO, ACK},
    '{KIND_DATA,  32'd0,          8'h00, 21'd1048576, CRC_ZERO, BY_MODEL},
    '{KIND_DATA,  32'd0,          8'hFF, 21'd1048575, CRC_ZERO, BY_MODEL},
    '{KIND_DATA,  32'd0,          8'h01, 21'd1,       CRC_ZERO, BY_MODEL},
    '{KIND_DATA,  32'd0,          8'h80, 21'd2,       CRC_ZERO, BY_MODEL},
    '{KIND_DATA,  32'd0,          8'h5A, 21'd3,       CRC_ZERO, BY_MODEL},
    '{KIND_DATA,  32'd0,          8'hA5, 21'd4,       CRC_ZERO, BY_MODEL},
    '{KIND_DATA,  32'd0,          8'h7E, 21'd1,       CRC_ZERO, BY_MODEL},
    '{KIND_DATA,  32'd0,          8'hC3, 21'd1,       CRC_ZERO, BY_MODEL},
    '{KIND_DATA,  32'd0,          8'h96, 21'd1,       CRC_ZERO, BY_MODEL},
    '{KIND_END,   32'd0,          8'h00, 21'd0,       CRC_GOOD, BY_MODEL},
    '{KIND_BEGIN, 32'd8,          8'h00, 21'd0,       CRC_ZERO, ACK},
    '{KIND_END,   32'd0,          8'h00, 21'd0,       CRC_BAD,  NAK},
    '{KIND_ABORT, 32'd0,          8'h00, 21'd0,       CRC_ZERO, ACK}
  };

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  fius_in_t  in_item = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  fius_out_t out_item;
  logic      cfg_we = 1'b0;
  logic      cfg_wdata = 1'b0;

  // predictor state
  bit          boot_slot = 1'b0;
  bit          armed = 1'b0;
  int unsigned wr_off = 0;
  int unsigned erase_mark = 0;
  logic [7:0]  sig_shadow [SIG_N] = '{default: SIG_FILL};
  logic [31:0] image_crc = CRC_INIT;

  fius_out_t   step_cmds[$];
  fius_out_t   due_flash_cmds[$];

  int unsigned mismatches = 0;
  int unsigned sent_items = 0;
  int unsigned calm_left = 0;
  int unsigned stall_hold_cycles = 0;

  flash_image_update_sequencer_top uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic logic [ADDR_W-1:0] slot_start(input bit s);
    return s ? SLOT1_BASE : SLOT0_BASE;
  endfunction

  function automatic logic [31:0] crc32_update(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    logic        fb;
    c = crc;
    for (int k = 0; k < 8; k++) begin
      fb = c[0] ^ b[k];
      c = c >> 1;
      if (fb) c = c ^ CRC_POLY;
    end
    return c;
  endfunction

  function automatic void add_cmd(input logic [1:0] op, input logic [ADDR_W-1:0] addr,
                                  input logic [7:0] b);
    step_cmds.push_back('{flash_op: op, flash_addr: addr, program_byte: b,
                          ok: 1'b0, last: 1'b0});
  endfunction

  // flash commands and status result of one request, left in step_cmds
  function automatic void predict_flash_cmds(input fius_in_t r);
    int unsigned tgt;
    int unsigned span;
    bit          accepted;
    tgt = 32'(slot_start(~boot_slot));
    accepted = 1'b1;
    step_cmds.delete();
    case (r.kind)
      KIND_BEGIN: begin
        if (r.image_size < SIG_N || r.image_size > SLOT_N) begin
          accepted = 1'b0;
        end else begin
          armed = 1'b1;
          wr_off = 0;
          erase_mark = 0;
          image_crc = CRC_INIT;
          foreach (sig_shadow[k]) sig_shadow[k] = SIG_FILL;
        end
      end
      KIND_DATA: begin
        span = (r.chunk_left == '0) ? 1 : 32'(r.chunk_left);
        if (!armed || wr_off + span > SLOT_N) begin
          accepted = 1'b0;
        end else begin
          // erase the next sector once the write offset reaches it
          if (erase_mark < wr_off + 1) begin
            add_cmd(OP_ERASE, ADDR_W'(tgt + erase_mark), 8'h00);
            erase_mark = erase_mark + SECTOR_N;
          end
          if (wr_off < SIG_N) sig_shadow[wr_off] = r.data_byte;
          else add_cmd(OP_PROGRAM, ADDR_W'(tgt + wr_off), r.data_byte);
          image_crc = crc32_update(image_crc, r.data_byte);
          wr_off = wr_off + 1;
        end
      end
      KIND_END: begin
        if (!armed) begin
          accepted = 1'b0;
        end else if (~image_crc != r.expected_crc) begin
          armed = 1'b0;
          wr_off = 0;
          accepted = 1'b0;
        end else begin
          for (int k = 0; k < SIG_N; k++) add_cmd(OP_PROGRAM, ADDR_W'(tgt + k), sig_shadow[k]);
          // invalidate the running image header
          for (int k = 0; k < 4; k++)
            add_cmd(OP_PROGRAM, ADDR_W'(32'(slot_start(boot_slot)) + k), 8'h00);
          armed = 1'b0;
        end
      end
      KIND_ABORT: begin
        armed = 1'b0;
        wr_off = 0;
      end
    endcase
    if (step_cmds.size() == 0) add_cmd(OP_STATUS, '0, 8'h00);
    foreach (step_cmds[k]) step_cmds[k].ok = accepted;
    step_cmds[step_cmds.size() - 1].last = 1'b1;
  endfunction

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    mismatches++;
    if (mismatches <= 40)
      $display("mismatch at %0t: %s got 0x%0h want 0x%0h", $time, what, got, want);
  endtask

  // called at a rising edge; returns at the edge where the request is taken
  task automatic issue_request(input fius_in_t r, input row_check_e chk);
    in_valid <= 1'b1;
    in_item  <= r;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent_items++;
    predict_flash_cmds(r);
    if (chk == BY_MODEL) begin
      foreach (step_cmds[k]) due_flash_cmds.push_back(step_cmds[k]);
    end else begin
      due_flash_cmds.push_back('{flash_op: OP_STATUS, flash_addr: '0, program_byte: 8'h00,
                                 ok: (chk == ACK), last: 1'b1});
    end
  endtask

  task automatic sender_idle();
    int unsigned g;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (calm_left != 0) begin
      calm_left--;
      g = 0;
    end else if (pick < 4) begin
      calm_left = $urandom_range(16, 40);
      g = 0;
    end else if (pick < 55) begin
      g = 0;
    end else if (pick < 85) begin
      g = $urandom_range(1, 3);
    end else if (pick < 95) begin
      g = $urandom_range(4, 8);
    end else begin
      g = $urandom_range(12, 24);
    end
    if (g != 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    do @(posedge clk); while (due_flash_cmds.size() != 0);
    repeat (IDLE_SETTLE) @(posedge clk);
  endtask

  task automatic write_running_slot(input bit s);
    cfg_we    <= 1'b1;
    cfg_wdata <= s;
    @(posedge clk);
    cfg_we    <= 1'b0;
    boot_slot = s;
  endtask

  function automatic fius_in_t noise_request();
    fius_in_t r;
    r.kind         = 2'($urandom_range(0, 3));
    r.image_size   = $urandom;
    r.data_byte    = 8'($urandom_range(0, 255));
    r.chunk_left   = 21'($urandom_range(0, 2097151));
    r.expected_crc = $urandom;
    return r;
  endfunction

  // one update: begin, data bytes, then end, abort or nothing
  task automatic send_image(input int unsigned nbytes);
    fius_in_t    r;
    int unsigned pick;
    r = noise_request();
    r.kind = KIND_BEGIN;
    pick = $urandom_range(0, 19);
    if (pick == 0) r.image_size = SIG_N;
    else if (pick == 1) r.image_size = SLOT_N;
    else if (pick == 2) r.image_size = SIG_N - 1;
    else if (pick != 3) r.image_size = $urandom_range(SIG_N, 4096);
    issue_request(r, BY_MODEL);
    sender_idle();
    for (int unsigned k = 0; k < nbytes; k++) begin
      r = noise_request();
      r.kind = KIND_DATA;
      pick = $urandom_range(0, 19);
      if (pick == 0) r.chunk_left = 21'(SLOT_N - wr_off);
      else if (pick == 1) r.chunk_left = 21'(SLOT_N - wr_off + 1);
      else if (pick != 2) r.chunk_left = 21'($urandom_range(0, 64));
      issue_request(r, BY_MODEL);
      sender_idle();
      if ($urandom_range(0, 63) == 0) wait_idle();
    end
    r = noise_request();
    pick = $urandom_range(0, 9);
    if (pick < 7) begin
      r.kind = KIND_END;
      r.expected_crc = ~image_crc;
    end else if (pick == 7) begin
      r.kind = KIND_END;
      r.expected_crc = ~image_crc ^ (32'd1 << $urandom_range(0, 31));
    end else if (pick == 8) begin
      r.kind = KIND_ABORT;
    end
    if (pick < 9) begin
      issue_request(r, BY_MODEL);
      sender_idle();
    end
  endtask

  // result check
  always @(posedge clk) begin : check_results
    fius_out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (due_flash_cmds.size() == 0) begin
        report_mismatch("result with no request pending", 32'(out_item.flash_addr), 0);
      end else begin
        want = due_flash_cmds.pop_front();
        if (out_item.flash_op != want.flash_op)
          report_mismatch("flash_op", 32'(out_item.flash_op), 32'(want.flash_op));
        if (out_item.flash_addr != want.flash_addr)
          report_mismatch("flash_addr", 32'(out_item.flash_addr), 32'(want.flash_addr));
        if (out_item.program_byte != want.program_byte)
          report_mismatch("program_byte", 32'(out_item.program_byte), 32'(want.program_byte));
        if (out_item.ok != want.ok)
          report_mismatch("ok", 32'(out_item.ok), 32'(want.ok));
        if (out_item.last != want.last)
          report_mismatch("last", 32'(out_item.last), 32'(want.last));
      end
    end
  end

  // result receiver: random stalls, plus a long hold-off on request
  initial begin : result_sink
    int unsigned n;
    int unsigned pick;
    forever begin
      pick = $urandom_range(0, 99);
      if (stall_hold_cycles != 0) begin
        n = stall_hold_cycles;
        stall_hold_cycles = 0;
        out_stall <= 1'b1;
      end else if (pick < 45) begin
        out_stall <= 1'b0;
        n = $urandom_range(1, 4);
      end else if (pick < 85) begin
        out_stall <= 1'b1;
        n = $urandom_range(1, 3);
      end else if (pick < 93) begin
        out_stall <= 1'b0;
        n = $urandom_range(20, 60);
      end else begin
        out_stall <= 1'b1;
        n = $urandom_range(8, 24);
      end
      repeat (n) @(posedge clk);
    end
  end

  initial begin : stimulus
    fius_in_t    r;
    int unsigned budget;
    int unsigned pick;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    for (int k = 0; k < 25; k++) begin
      r.kind         = DIRECTED_SCRIPT[k].kind;
      r.image_size   = DIRECTED_SCRIPT[k].image_size;
      r.data_byte    = DIRECTED_SCRIPT[k].data_byte;
      r.chunk_left   = DIRECTED_SCRIPT[k].chunk_left;
      case (DIRECTED_SCRIPT[k].crc_fill)
        CRC_GOOD: r.expected_crc = ~image_crc;
        CRC_BAD:  r.expected_crc = ~image_crc ^ 32'h1;
        default:  r.expected_crc = '0;
      endcase
      issue_request(r, DIRECTED_SCRIPT[k].check);
      sender_idle();
    end

    for (int ph = 0; ph < 4; ph++) begin
      wait_idle();
      write_running_slot(ph[0] == 1'b0);
      // receiver holds off while requests keep coming
      if (ph == 1) stall_hold_cycles = 300;
      budget = sent_items + PHASE_ITEMS;
      while (sent_items < budget) begin
        pick = $urandom_range(0, 99);
        if (pick < 78) begin
          if ($urandom_range(0, 4) == 0) send_image($urandom_range(15, 30));
          else send_image($urandom_range(0, 14));
        end else if (pick < 97) begin
          issue_request(noise_request(), BY_MODEL);
          sender_idle();
        end else begin
          wait_idle();
        end
      end
    end

    wait_idle();
    repeat (DRAIN_TAIL) @(posedge clk);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin : watchdog
    #8_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule
